/* rtl/core/vau_pkg.sv */
`timescale 1ns / 1ps

package vau_pkg;

   // component format
   localparam int CW = 32;
   localparam int FB = 16;

   // multiplier lanes: three for scale, dot and squares, six for cross
   localparam int NPROD = 6;

   // working width before clamping: sum of three truncated products
   localparam int SUM_W = 2 * CW - FB + 2;

   // integer square root over the sum of squares
   localparam int RAD_W    = 2 * CW;
   localparam int SQ_STEPS = CW;
   localparam int SQ_REM_W = CW + 3;

   // normalize quotient never exceeds one, so FB + 1 quotient bits
   localparam int DIV_STEPS = FB + 1;
   localparam int NUM_W     = CW + FB;

   // half an integer for round to nearest
   localparam logic [CW:0] RND_HALF = (CW + 1)'(1) << (FB - 1);

   typedef logic signed [CW-1:0] comp_type;

   typedef enum logic [2:0] {
      ACT_ADD,
      ACT_SUB,
      ACT_SCALE,
      ACT_CROSS,
      ACT_DOT,
      ACT_LENGTH,
      ACT_NORM,
      ACT_ROUND
   } act_type;

   // result and operand a traveling down the pipe
   typedef struct packed {
      act_type  action;
      logic     sat;
      comp_type rx;
      comp_type ry;
      comp_type rz;
      comp_type rs;
      comp_type ax;
      comp_type ay;
      comp_type az;
   } tail_type;

   typedef struct packed {
      logic     sat;
      comp_type value;
   } sat_type;

   // clamp a wide signed value to the component range
   function automatic sat_type sat_clamp(input logic signed [SUM_W-1:0] v);
      sat_type r;
      if (v[SUM_W-1:CW-1] == {(SUM_W - CW + 1){v[SUM_W-1]}}) begin
         r.sat   = 1'b0;
         r.value = v[CW-1:0];
      end else begin
         r.sat   = 1'b1;
         r.value = v[SUM_W-1] ? {1'b1, {(CW - 1){1'b0}}} : {1'b0, {(CW - 1){1'b1}}};
      end
      return r;
   endfunction

endpackage

/* rtl/core/vector3_arith_unit.sv */
// every action takes the same path from the accepting edge to rsp_valid
// throughput: one beat per cycle while the output is not stalled; operand select,
//   multiply, combine, 32 square root steps, length and divider setup, 17 divide
//   steps and the output register each take one stage
// a stalled output holds the whole pipe, and req_ready follows the output register
// reset clears the valid bits only; the pipe is empty after reset
`timescale 1ns / 1ps

module vector3_arith_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_action,
   input  logic signed [vau_pkg::CW-1:0] req_a_x,
   input  logic signed [vau_pkg::CW-1:0] req_a_y,
   input  logic signed [vau_pkg::CW-1:0] req_a_z,
   input  logic signed [vau_pkg::CW-1:0] req_b_x,
   input  logic signed [vau_pkg::CW-1:0] req_b_y,
   input  logic signed [vau_pkg::CW-1:0] req_b_z,
   input  logic signed [vau_pkg::CW-1:0] req_scale_factor,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [vau_pkg::CW-1:0] rsp_result_x,
   output logic signed [vau_pkg::CW-1:0] rsp_result_y,
   output logic signed [vau_pkg::CW-1:0] rsp_result_z,
   output logic signed [vau_pkg::CW-1:0] rsp_result_scalar,
   output logic                          rsp_saturated
);

   localparam int CW        = vau_pkg::CW;
   localparam int FB        = vau_pkg::FB;
   localparam int NPROD     = vau_pkg::NPROD;
   localparam int SUM_W     = vau_pkg::SUM_W;
   localparam int RAD_W     = vau_pkg::RAD_W;
   localparam int SQ_STEPS  = vau_pkg::SQ_STEPS;
   localparam int SQ_REM_W  = vau_pkg::SQ_REM_W;
   localparam int DIV_STEPS = vau_pkg::DIV_STEPS;
   localparam int NUM_W     = vau_pkg::NUM_W;

   logic adv;

   // operand stage
   vau_pkg::act_type  act_in;
   vau_pkg::comp_type req_a [3];
   vau_pkg::comp_type req_b [3];
   vau_pkg::comp_type opa_in [NPROD];
   vau_pkg::comp_type opb_in [NPROD];
   logic              va_ff;
   vau_pkg::act_type  acta_ff;
   vau_pkg::comp_type aa_ff [3];
   vau_pkg::comp_type ba_ff [3];
   vau_pkg::comp_type opa_ff [NPROD];
   vau_pkg::comp_type opb_ff [NPROD];

   // product stage
   logic                     vb_ff;
   vau_pkg::act_type         actb_ff;
   vau_pkg::comp_type        ab_ff [3];
   vau_pkg::comp_type        bb_ff [3];
   logic signed [2*CW-1:0]   prod_in [NPROD];
   logic signed [2*CW-1:0]   prod_ff [NPROD];

   // combine stage
   logic signed [2*CW-FB-1:0] tp [NPROD];
   logic signed [SUM_W-1:0]   wv [3];
   logic signed [SUM_W-1:0]   ws;
   logic [CW-1:0]             rmag [3];
   logic [CW:0]               rsum [3];
   logic [CW:0]               rnd [3];
   logic signed [SUM_W-1:0]   rw [3];
   vau_pkg::sat_type          clp [3];
   vau_pkg::sat_type          clps;

   // square root stages
   logic              vs_ff   [0:SQ_STEPS];
   vau_pkg::tail_type ts_in   [0:SQ_STEPS];
   vau_pkg::tail_type ts_ff   [0:SQ_STEPS];
   logic [RAD_W-1:0]  rad_in  [0:SQ_STEPS];
   logic [RAD_W-1:0]  rad_ff  [0:SQ_STEPS];
   logic [SQ_REM_W-1:0] srem_in [0:SQ_STEPS];
   logic [SQ_REM_W-1:0] srem_ff [0:SQ_STEPS];
   logic [CW-1:0]     root_in [0:SQ_STEPS];
   logic [CW-1:0]     root_ff [0:SQ_STEPS];
   logic [SQ_REM_W-1:0] sq_sh  [SQ_STEPS];
   logic [SQ_REM_W-1:0] sq_try [SQ_STEPS];
   logic              sq_ge   [SQ_STEPS];

   // divide stages
   vau_pkg::comp_type   sa [3];
   logic [CW-1:0]       smag [3];
   logic [NUM_W-1:0]    numer [3];
   logic                vd_ff   [0:DIV_STEPS];
   vau_pkg::tail_type   td_in   [0:DIV_STEPS];
   vau_pkg::tail_type   td_ff   [0:DIV_STEPS];
   logic [CW-1:0]       len_in  [0:DIV_STEPS];
   logic [CW-1:0]       len_ff  [0:DIV_STEPS];
   logic [CW-1:0]       drem_in [0:DIV_STEPS][3];
   logic [CW-1:0]       drem_ff [0:DIV_STEPS][3];
   logic [DIV_STEPS-1:0] nb_in  [0:DIV_STEPS][3];
   logic [DIV_STEPS-1:0] nb_ff  [0:DIV_STEPS][3];
   logic [DIV_STEPS-1:0] q_in   [0:DIV_STEPS][3];
   logic [DIV_STEPS-1:0] q_ff   [0:DIV_STEPS][3];
   logic [CW:0]         dv_sh   [DIV_STEPS][3];
   logic                dv_ge   [DIV_STEPS][3];

   // output stage
   vau_pkg::comp_type   fa [3];
   logic [CW-1:0]       qz [3];
   vau_pkg::comp_type   nv [3];
   vau_pkg::tail_type   out_in;
   vau_pkg::tail_type   out_ff;
   logic                vo_ff;

   // whole pipe moves unless the output beat is stalled
   assign adv       = !vo_ff || rsp_ready;
   assign req_ready = adv;

   assign act_in   = vau_pkg::act_type'(req_action);
   assign req_a[0] = req_a_x;
   assign req_a[1] = req_a_y;
   assign req_a[2] = req_a_z;
   assign req_b[0] = req_b_x;
   assign req_b[1] = req_b_y;
   assign req_b[2] = req_b_z;

   // multiplier operand select
   always_comb begin
      for (int i = 0; i < NPROD; i++) begin
         opa_in[i] = '0;
         opb_in[i] = '0;
      end
      unique case (act_in)
         vau_pkg::ACT_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               opa_in[i] = req_a[i];
               opb_in[i] = req_scale_factor;
            end
         end
         vau_pkg::ACT_CROSS: begin
            opa_in[0] = req_a[1]; opb_in[0] = req_b[2];
            opa_in[1] = req_a[2]; opb_in[1] = req_b[1];
            opa_in[2] = req_a[2]; opb_in[2] = req_b[0];
            opa_in[3] = req_a[0]; opb_in[3] = req_b[2];
            opa_in[4] = req_a[0]; opb_in[4] = req_b[1];
            opa_in[5] = req_a[1]; opb_in[5] = req_b[0];
         end
         vau_pkg::ACT_DOT: begin
            for (int i = 0; i < 3; i++) begin
               opa_in[i] = req_a[i];
               opb_in[i] = req_b[i];
            end
         end
         vau_pkg::ACT_LENGTH, vau_pkg::ACT_NORM: begin
            for (int i = 0; i < 3; i++) begin
               opa_in[i] = req_a[i];
               opb_in[i] = req_a[i];
            end
         end
         vau_pkg::ACT_ADD, vau_pkg::ACT_SUB, vau_pkg::ACT_ROUND: begin
         end
      endcase
   end

   // full width products
   always_comb begin
      for (int i = 0; i < NPROD; i++) begin
         prod_in[i] = opa_ff[i] * opb_ff[i];
      end
   end

   // combine products, add, subtract, round and clamp
   always_comb begin
      for (int i = 0; i < NPROD; i++) begin
         tp[i] = prod_ff[i][2*CW-1:FB];
      end
      for (int i = 0; i < 3; i++) begin
         rmag[i] = ab_ff[i][CW-1] ? CW'(-ab_ff[i]) : ab_ff[i];
         rsum[i] = {1'b0, rmag[i]} + vau_pkg::RND_HALF;
         rnd[i]  = {rsum[i][CW:FB], {FB{1'b0}}};
         rw[i]   = SUM_W'(rnd[i]);
         wv[i]   = '0;
      end
      ws = '0;
      unique case (actb_ff)
         vau_pkg::ACT_ADD: begin
            for (int i = 0; i < 3; i++) wv[i] = SUM_W'(ab_ff[i]) + SUM_W'(bb_ff[i]);
         end
         vau_pkg::ACT_SUB: begin
            for (int i = 0; i < 3; i++) wv[i] = SUM_W'(ab_ff[i]) - SUM_W'(bb_ff[i]);
         end
         vau_pkg::ACT_SCALE: begin
            for (int i = 0; i < 3; i++) wv[i] = SUM_W'(tp[i]);
         end
         vau_pkg::ACT_CROSS: begin
            wv[0] = SUM_W'(tp[0]) - SUM_W'(tp[1]);
            wv[1] = SUM_W'(tp[2]) - SUM_W'(tp[3]);
            wv[2] = SUM_W'(tp[4]) - SUM_W'(tp[5]);
         end
         vau_pkg::ACT_DOT: begin
            ws = SUM_W'(tp[0]) + SUM_W'(tp[1]) + SUM_W'(tp[2]);
         end
         vau_pkg::ACT_ROUND: begin
            for (int i = 0; i < 3; i++) wv[i] = ab_ff[i][CW-1] ? -rw[i] : rw[i];
         end
         vau_pkg::ACT_LENGTH, vau_pkg::ACT_NORM: begin
         end
      endcase
      for (int i = 0; i < 3; i++) clp[i] = vau_pkg::sat_clamp(wv[i]);
      clps = vau_pkg::sat_clamp(ws);

      ts_in[0].action = actb_ff;
      ts_in[0].sat    = clp[0].sat | clp[1].sat | clp[2].sat | clps.sat;
      ts_in[0].rx     = clp[0].value;
      ts_in[0].ry     = clp[1].value;
      ts_in[0].rz     = clp[2].value;
      ts_in[0].rs     = clps.value;
      ts_in[0].ax     = ab_ff[0];
      ts_in[0].ay     = ab_ff[1];
      ts_in[0].az     = ab_ff[2];
      // sum of squares, below 2^RAD_W
      rad_in[0]  = RAD_W'(prod_ff[0]) + RAD_W'(prod_ff[1]) + RAD_W'(prod_ff[2]);
      srem_in[0] = '0;
      root_in[0] = '0;

      // square root, one result bit per stage
      for (int j = 0; j < SQ_STEPS; j++) begin
         sq_sh[j]  = {srem_ff[j][SQ_REM_W-3:0], rad_ff[j][RAD_W-1 -: 2]};
         sq_try[j] = SQ_REM_W'({root_ff[j], 2'b01});
         sq_ge[j]  = sq_sh[j] >= sq_try[j];
         srem_in[j+1] = sq_ge[j] ? sq_sh[j] - sq_try[j] : sq_sh[j];
         root_in[j+1] = {root_ff[j][CW-2:0], sq_ge[j]};
         rad_in[j+1]  = {rad_ff[j][RAD_W-3:0], 2'b00};
         ts_in[j+1]   = ts_ff[j];
      end
   end

   // length result and divider setup
   always_comb begin
      sa[0] = ts_ff[SQ_STEPS].ax;
      sa[1] = ts_ff[SQ_STEPS].ay;
      sa[2] = ts_ff[SQ_STEPS].az;
      len_in[0] = root_ff[SQ_STEPS];
      td_in[0]  = ts_ff[SQ_STEPS];
      if (ts_ff[SQ_STEPS].action == vau_pkg::ACT_LENGTH) begin
         td_in[0].sat = root_ff[SQ_STEPS][CW-1];
         td_in[0].rs  = root_ff[SQ_STEPS][CW-1] ? {1'b0, {(CW - 1){1'b1}}}
                                                : root_ff[SQ_STEPS];
      end
      for (int l = 0; l < 3; l++) begin
         smag[l]       = sa[l][CW-1] ? CW'(-sa[l]) : sa[l];
         numer[l]      = {smag[l], {FB{1'b0}}};
         drem_in[0][l] = CW'(numer[l][NUM_W-1:DIV_STEPS]);
         nb_in[0][l]   = numer[l][DIV_STEPS-1:0];
         q_in[0][l]    = '0;
      end

      // restoring divide, one quotient bit per stage in each lane
      for (int j = 0; j < DIV_STEPS; j++) begin
         td_in[j+1]  = td_ff[j];
         len_in[j+1] = len_ff[j];
         for (int l = 0; l < 3; l++) begin
            dv_sh[j][l] = {drem_ff[j][l], nb_ff[j][l][DIV_STEPS-1]};
            dv_ge[j][l] = dv_sh[j][l] >= {1'b0, len_ff[j]};
            drem_in[j+1][l] = dv_ge[j][l] ? CW'(dv_sh[j][l] - {1'b0, len_ff[j]})
                                          : dv_sh[j][l][CW-1:0];
            nb_in[j+1][l] = {nb_ff[j][l][DIV_STEPS-2:0], 1'b0};
            q_in[j+1][l]  = {q_ff[j][l][DIV_STEPS-2:0], dv_ge[j][l]};
         end
      end
   end

   // normalize result, zero vector for zero length
   always_comb begin
      fa[0] = td_ff[DIV_STEPS].ax;
      fa[1] = td_ff[DIV_STEPS].ay;
      fa[2] = td_ff[DIV_STEPS].az;
      for (int l = 0; l < 3; l++) begin
         qz[l] = (len_ff[DIV_STEPS] == '0) ? '0 : CW'(q_ff[DIV_STEPS][l]);
         nv[l] = fa[l][CW-1] ? -qz[l] : qz[l];
      end
      out_in = td_ff[DIV_STEPS];
      if (td_ff[DIV_STEPS].action == vau_pkg::ACT_NORM) begin
         out_in.rx = nv[0];
         out_in.ry = nv[1];
         out_in.rz = nv[2];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vo_ff <= 1'b0;
         for (int j = 0; j <= SQ_STEPS; j++) vs_ff[j] <= 1'b0;
         for (int j = 0; j <= DIV_STEPS; j++) vd_ff[j] <= 1'b0;
      end else if (adv) begin
         va_ff    <= req_valid;
         vb_ff    <= va_ff;
         vs_ff[0] <= vb_ff;
         for (int j = 0; j < SQ_STEPS; j++) vs_ff[j+1] <= vs_ff[j];
         vd_ff[0] <= vs_ff[SQ_STEPS];
         for (int j = 0; j < DIV_STEPS; j++) vd_ff[j+1] <= vd_ff[j];
         vo_ff    <= vd_ff[DIV_STEPS];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         acta_ff <= act_in;
         actb_ff <= acta_ff;
         for (int i = 0; i < 3; i++) begin
            aa_ff[i] <= req_a[i];
            ba_ff[i] <= req_b[i];
            ab_ff[i] <= aa_ff[i];
            bb_ff[i] <= ba_ff[i];
         end
         for (int i = 0; i < NPROD; i++) begin
            opa_ff[i]  <= opa_in[i];
            opb_ff[i]  <= opb_in[i];
            prod_ff[i] <= prod_in[i];
         end
         for (int j = 0; j <= SQ_STEPS; j++) begin
            ts_ff[j]   <= ts_in[j];
            rad_ff[j]  <= rad_in[j];
            srem_ff[j] <= srem_in[j];
            root_ff[j] <= root_in[j];
         end
         for (int j = 0; j <= DIV_STEPS; j++) begin
            td_ff[j]  <= td_in[j];
            len_ff[j] <= len_in[j];
            for (int l = 0; l < 3; l++) begin
               drem_ff[j][l] <= drem_in[j][l];
               nb_ff[j][l]   <= nb_in[j][l];
               q_ff[j][l]    <= q_in[j][l];
            end
         end
         out_ff <= out_in;
      end
   end

   assign rsp_valid         = vo_ff;
   assign rsp_result_x      = out_ff.rx;
   assign rsp_result_y      = out_ff.ry;
   assign rsp_result_z      = out_ff.rz;
   assign rsp_result_scalar = out_ff.rs;
   assign rsp_saturated     = out_ff.sat;

   // divider remainders stay below the length at the last step
   a_div_rem : assert property (@(posedge clock) disable iff (reset)
      vd_ff[DIV_STEPS] && td_ff[DIV_STEPS].action == vau_pkg::ACT_NORM
         && len_ff[DIV_STEPS] != '0
      |-> drem_ff[DIV_STEPS][0] < len_ff[DIV_STEPS]
          && drem_ff[DIV_STEPS][1] < len_ff[DIV_STEPS]
          && drem_ff[DIV_STEPS][2] < len_ff[DIV_STEPS])
      else $error("normalize remainder not below length");

   // normalize never clamps
   a_norm_nosat : assert property (@(posedge clock) disable iff (reset)
      vo_ff && out_ff.action == vau_pkg::ACT_NORM |-> !rsp_saturated)
      else $error("normalize beat flagged saturated");

   // vector actions leave the scalar at zero
   a_vec_scalar : assert property (@(posedge clock) disable iff (reset)
      vo_ff && (out_ff.action == vau_pkg::ACT_ADD || out_ff.action == vau_pkg::ACT_SUB
         || out_ff.action == vau_pkg::ACT_SCALE || out_ff.action == vau_pkg::ACT_CROSS
         || out_ff.action == vau_pkg::ACT_NORM || out_ff.action == vau_pkg::ACT_ROUND)
      |-> rsp_result_scalar == '0)
      else $error("scalar nonzero on vector beat");

   // length is non-negative with a zero vector
   a_len_shape : assert property (@(posedge clock) disable iff (reset)
      vo_ff && out_ff.action == vau_pkg::ACT_LENGTH
      |-> !rsp_result_scalar[CW-1] && rsp_result_x == '0
          && rsp_result_y == '0 && rsp_result_z == '0)
      else $error("length beat malformed");

   // pipe is empty right after reset
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule

/* bench/vau_checker.sv */
`timescale 1ns / 1ps

module vau_checker
   import vau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_action,
   input  comp_type    req_a_x,
   input  comp_type    req_a_y,
   input  comp_type    req_a_z,
   input  comp_type    req_b_x,
   input  comp_type    req_b_y,
   input  comp_type    req_b_z,
   input  comp_type    req_scale_factor,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  comp_type    rsp_result_x,
   input  comp_type    rsp_result_y,
   input  comp_type    rsp_result_z,
   input  comp_type    rsp_result_scalar,
   input  logic        rsp_saturated,
   output int          fail_count,
   output int          pending
);

   localparam longint CMAX_L = 64'sd2147483647;
   localparam longint CMIN_L = -64'sd2147483648;

   typedef struct {
      comp_type x;
      comp_type y;
      comp_type z;
      comp_type s;
      logic     sat;
   } vec_result_t;

   vec_result_t result_q[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // clamp to the component range, noting any clamp
   function automatic comp_type clamp_comp(input longint v, inout bit sat);
      if (v > CMAX_L) begin
         sat = 1'b1;
         return comp_type'(CMAX_L);
      end
      if (v < CMIN_L) begin
         sat = 1'b1;
         return comp_type'(CMIN_L);
      end
      return comp_type'(v);
   endfunction

   // full-width product, then arithmetic shift by the fraction bits
   function automatic longint fixmul(input longint a, input longint b);
      longint p;
      p = a * b;
      return p >>> FB;
   endfunction

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // bitwise integer square root
   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned root;
      longint unsigned b;
      root = 0;
      b    = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n    = n - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic longint unsigned vec_length(input longint ax, input longint ay,
                                                  input longint az);
      return int_sqrt(magnitude(ax) * magnitude(ax) + magnitude(ay) * magnitude(ay)
                      + magnitude(az) * magnitude(az));
   endfunction

   // nearest integer value, halves away from zero
   function automatic longint round_half_away(input longint v);
      longint unsigned m;
      m = ((magnitude(v) + (64'd1 << (FB - 1))) >> FB) << FB;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic vec_result_t vec_predict(input act_type act, input comp_type ax_c,
      input comp_type ay_c, input comp_type az_c, input comp_type bx_c, input comp_type by_c,
      input comp_type bz_c, input comp_type k_c);
      vec_result_t r;
      bit sat;
      longint a[3];
      longint b[3];
      longint k;
      longint v;
      longint unsigned len;
      longint unsigned q;
      comp_type c[3];
      a = '{ax_c, ay_c, az_c};
      b = '{bx_c, by_c, bz_c};
      k = k_c;
      sat = 1'b0;
      c = '{0, 0, 0};
      r.s = '0;
      case (act)
         ACT_ADD: for (int i = 0; i < 3; i++) c[i] = clamp_comp(a[i] + b[i], sat);
         ACT_SUB: for (int i = 0; i < 3; i++) c[i] = clamp_comp(a[i] - b[i], sat);
         ACT_SCALE: for (int i = 0; i < 3; i++) c[i] = clamp_comp(fixmul(a[i], k), sat);
         ACT_CROSS: begin
            c[0] = clamp_comp(fixmul(a[1], b[2]) - fixmul(a[2], b[1]), sat);
            c[1] = clamp_comp(fixmul(a[2], b[0]) - fixmul(a[0], b[2]), sat);
            c[2] = clamp_comp(fixmul(a[0], b[1]) - fixmul(a[1], b[0]), sat);
         end
         ACT_DOT: begin
            r.s = clamp_comp(fixmul(a[0], b[0]) + fixmul(a[1], b[1])
                             + fixmul(a[2], b[2]), sat);
         end
         ACT_LENGTH: begin
            len = vec_length(a[0], a[1], a[2]);
            r.s = clamp_comp((len > CMAX_L) ? CMAX_L + 1 : longint'(len), sat);
         end
         ACT_NORM: begin
            len = vec_length(a[0], a[1], a[2]);
            if (len != 0) begin
               for (int i = 0; i < 3; i++) begin
                  q = (magnitude(a[i]) << FB) / len;
                  v = (q > CMAX_L + 1) ? CMAX_L + 1 : longint'(q);
                  c[i] = clamp_comp((a[i] < 0) ? -v : v, sat);
               end
            end
         end
         default: for (int i = 0; i < 3; i++) c[i] = clamp_comp(round_half_away(a[i]), sat);
      endcase
      r.x   = c[0];
      r.y   = c[1];
      r.z   = c[2];
      r.sat = sat;
      return r;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   // predict on each request beat, compare on each result beat
   always @(posedge clock) begin
      vec_result_t want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            result_q.push_back(vec_predict(act_type'(req_action), req_a_x, req_a_y, req_a_z,
                                           req_b_x, req_b_y, req_b_z, req_scale_factor));
         end
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               report("unexpected beat", 0, 0);
            end else begin
               want = result_q.pop_front();
               if (rsp_result_x !== want.x) report("result_x", rsp_result_x, want.x);
               if (rsp_result_y !== want.y) report("result_y", rsp_result_y, want.y);
               if (rsp_result_z !== want.z) report("result_z", rsp_result_z, want.z);
               if (rsp_result_scalar !== want.s)
                  report("result_scalar", rsp_result_scalar, want.s);
               if (rsp_saturated !== want.sat) report("saturated", rsp_saturated, want.sat);
            end
         end
      end
      pending <= result_q.size();
   end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
   import vau_pkg::*;

   localparam comp_type Q_MAX = 32'sh7fffffff;
   localparam comp_type Q_MIN = 32'sh80000000;
   localparam comp_type Q_ONE = 32'sh00010000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_action = '0;
   comp_type   req_a_x = '0, req_a_y = '0, req_a_z = '0;
   comp_type   req_b_x = '0, req_b_y = '0, req_b_z = '0;
   comp_type   req_scale_factor = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   comp_type   rsp_result_x, rsp_result_y, rsp_result_z, rsp_result_scalar;
   logic       rsp_saturated;
   int         fail_count;
   int         pending;
   int         burst_left = 0;

   vector3_arith_unit DUT (.*);
   vau_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stall pattern: the mode is redrawn now and then among always ready, random and mostly stalled
   always @(posedge clock) begin
      int unsigned mode_cnt;
      int unsigned mode;
      mode_cnt++;
      if (mode_cnt % 300 == 0) mode = $urandom_range(2, 0);
      case (mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(1, 0) == 1);
         default: rsp_ready <= ($urandom_range(7, 0) == 0);
      endcase
   end

   // one request beat; valid stays high inside a burst
   task automatic send_beat(input act_type act, input comp_type ax, input comp_type ay,
                            input comp_type az, input comp_type bx, input comp_type by,
                            input comp_type bz, input comp_type k);
      int gap;
      req_valid        <= 1'b1;
      req_action       <= act;
      req_a_x          <= ax;
      req_a_y          <= ay;
      req_a_z          <= az;
      req_b_x          <= bx;
      req_b_y          <= by;
      req_b_z          <= bz;
      req_scale_factor <= k;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(20, 0);
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // component mix: full range, small values, edges and halves
   function automatic comp_type rand_comp();
      case ($urandom_range(5, 0))
         0, 1: return comp_type'($urandom);
         2:    return comp_type'($urandom_range(32'h0020_0000, 0)) - 32'sh0010_0000;
         3:    return comp_type'({$urandom_range(65535, 0), 16'h8000});
         4:    return comp_type'($urandom_range(32'h0400_0000, 0)) - 32'sh0200_0000;
         default: begin
            case ($urandom_range(5, 0))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return '0;
               3: return -32'sd1;
               4: return Q_ONE;
               default: return -Q_ONE;
            endcase
         end
      endcase
   endfunction

   initial begin
      #200ms;
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: edges, every action, saturation and zero length
      send_beat(ACT_ADD, Q_MAX, Q_MIN, 0, Q_MAX, Q_MIN, 0, 0);
      send_beat(ACT_ADD, Q_ONE, -Q_ONE, 5, 7, 3, -9, Q_MAX);
      send_beat(ACT_SUB, Q_MIN, Q_MAX, 0, Q_MAX, Q_MIN, -1, 0);
      send_beat(ACT_SCALE, Q_MAX, Q_MIN, Q_ONE, 0, 0, 0, Q_MAX);
      send_beat(ACT_SCALE, Q_ONE, -Q_ONE, 32'sh0001_8000, Q_MAX, Q_MIN, 1, -Q_ONE);
      send_beat(ACT_SCALE, -32'sd1, 32'sd1, Q_MIN, 0, 0, 0, Q_MIN);
      send_beat(ACT_CROSS, Q_ONE, 0, 0, 0, Q_ONE, 0, Q_MAX);
      send_beat(ACT_CROSS, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0);
      send_beat(ACT_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0);
      send_beat(ACT_DOT, -32'sd1, -32'sd1, 1, 1, 1, -1, 0);
      send_beat(ACT_LENGTH, 0, 0, 0, Q_MAX, Q_MIN, 1, Q_MAX);
      send_beat(ACT_LENGTH, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0);
      send_beat(ACT_LENGTH, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0, 0);
      send_beat(ACT_NORM, 0, 0, 0, 1, 1, 1, 1);
      send_beat(ACT_NORM, Q_MIN, 0, 0, 0, 0, 0, 0);
      send_beat(ACT_NORM, 32'sd1, -32'sd1, 32'sd1, 0, 0, 0, 0);
      send_beat(ACT_NORM, Q_MAX, Q_MIN, Q_MAX, 0, 0, 0, 0);
      send_beat(ACT_ROUND, 32'sh7fff_8000, Q_MAX, Q_MIN, 0, 0, 0, 0);
      send_beat(ACT_ROUND, 32'shfffe_8000, 32'sh0000_8000, 32'sh0000_7fff, 0, 0, 0, 0);
      send_beat(ACT_ROUND, -32'sd1, 32'shffff_7fff, 32'sh8000_8000, 0, 0, 0, 0);

      // random part, with one drain pause midway
      for (int n = 0; n < 1000; n++) begin
         if (n == 500) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         send_beat(act_type'($urandom_range(7, 0)), rand_comp(), rand_comp(), rand_comp(),
                   rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
